// ===== hdl/cda_pkg.sv =====
// shared widths, constants, op codes and the month start table of the date unit
package cda_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int OP_W   = 2;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int FRAC_W = 31;

  // internal day number, counted from a point 400 years before 0000-03-01
  localparam int DN_W = 23;
  // day number within the civil window, counted from 0000-03-01
  localparam int Z_W  = 22;

  localparam int unsigned DAYS_YEAR = 365;
  localparam int unsigned DAYS_HALF = 182;
  localparam int unsigned ERA_DAYS  = 146097;
  localparam int unsigned YR_OFS    = 400;
  // 9999-12-31 in the civil window; 0001-01-01 lands on 306
  localparam int unsigned Z_MIN     = 306;
  localparam int unsigned Z_MAX     = 3652364;

  // reciprocal of 365, exact for quotients below 5000 with any remainder
  localparam int          S365 = 26;
  localparam logic [18:0] K365 = 19'(((64'd1 << S365) + 64'd364) / 64'd365);

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2
  } op_e;

  typedef struct packed {
    op_e  op;
    logic a_before_b;
    logic dates_equal;
  } ctl_t;

  // days from the first of march to the first of the month, march-based index
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/civil_date_arithmetic_unit.sv =====
// top level of the civil date unit: date shift by a year fraction and date difference
// done_o is registered together with the result fields, marking the word that they hold
// throughput: one word per cycle; busy stays low, no stage holds more than one wide
//   constant multiply in series, the deepest part being the civil date conversion (eight stages)
// reset clears only the valid pipeline; done_o pulses once per word and cannot be held off
module civil_date_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = cda_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [cda_pkg::OP_W-1:0]           op_i,
  input  logic [cda_pkg::YEAR_W-1:0]         a_year_i,
  input  logic [cda_pkg::MON_W-1:0]          a_month_i,
  input  logic [cda_pkg::DAY_W-1:0]          a_day_i,
  input  logic [cda_pkg::YEAR_W-1:0]         b_year_i,
  input  logic [cda_pkg::MON_W-1:0]          b_month_i,
  input  logic [cda_pkg::DAY_W-1:0]          b_day_i,
  input  logic signed [cda_pkg::FRAC_W-1:0]  year_frac_i,
  output logic                               done_o,
  output logic [cda_pkg::YEAR_W-1:0]         res_year_o,
  output logic [cda_pkg::MON_W-1:0]          res_month_o,
  output logic [cda_pkg::DAY_W-1:0]          res_day_o,
  output logic signed [cda_pkg::FRAC_W-1:0]  year_diff_o,
  output logic                               a_before_b_o,
  output logic                               dates_equal_o,
  output logic                               out_of_range_o
);
  import cda_pkg::*;

  // whole days from a scaled fraction, and the signed width that holds a shifted date
  localparam int PW  = FRAC_W + 8;
  localparam int SHW = PW + 1 - FRAC_BITS;
  localparam int NW  = ((DN_W > SHW) ? DN_W : SHW) + 2;
  localparam int LAST = 11;

  // the pipeline never stalls, so a word is taken whenever start is high
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 1: flags on the raw fields, magnitude of the fraction times 365
  // ---------------------------------------------------------------------------
  logic [FRAC_W-1:0] yf;
  logic [FRAC_W-1:0] fmag;
  ctl_t              ctl_d;
  ctl_t              ctl_q [1:LAST];
  logic [PW-1:0]     prod1_d, prod1_q;
  logic              neg1_q;

  always_comb begin
    yf               = year_frac_i;
    fmag             = yf[FRAC_W-1] ? FRAC_W'(-yf) : yf;
    prod1_d          = PW'(fmag) * PW'(DAYS_YEAR);
    ctl_d.op         = op_e'(op_i);
    // lexicographic order equals the order of the concatenated fields
    ctl_d.a_before_b = {a_year_i, a_month_i, a_day_i} < {b_year_i, b_month_i, b_day_i};
    ctl_d.dates_equal = (a_year_i == b_year_i) && (a_month_i == b_month_i)
                     && (a_day_i == b_day_i);
  end

  // day numbers of both dates come out of two-stage converters, aligned with stage 2
  logic [DN_W-1:0] dn_a, dn_b;

  cda_day_num u_dn_a (
    .clk_i   (clk_i),
    .year_i  (a_year_i),
    .month_i (a_month_i),
    .day_i   (a_day_i),
    .dnum_o  (dn_a)
  );

  cda_day_num u_dn_b (
    .clk_i   (clk_i),
    .year_i  (b_year_i),
    .month_i (b_month_i),
    .day_i   (b_day_i),
    .dnum_o  (dn_b)
  );

  // ---------------------------------------------------------------------------
  // stage 2: round half away from zero to whole days
  // ---------------------------------------------------------------------------
  logic [PW:0]    rnd;
  logic [SHW-1:0] sh2_d, sh2_q;
  logic           neg2_q;

  always_comb begin
    rnd   = (PW+1)'(prod1_q) + ((PW+1)'(1) << (FRAC_BITS - 1));
    sh2_d = SHW'(rnd >> FRAC_BITS);
  end

  // ---------------------------------------------------------------------------
  // stage 3: shifted date in the civil window with range check, or the
  // difference of the two day numbers split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic [NW-1:0]   delta, zf;
  logic            flip;
  logic [DN_W:0]   dd;
  logic [Z_W-1:0]  z3_d, z3_q;
  logic            oor3_d;
  logic [DN_W-1:0] mag3_d, mag3_q;
  logic            dneg3_q;

  always_comb begin
    flip   = (ctl_q[2].op == OP_SUB) ^ neg2_q;
    delta  = flip ? NW'(-NW'(sh2_q)) : NW'(sh2_q);
    zf     = NW'(dn_a) - NW'(ERA_DAYS) + delta;
    // the window holds exactly the years 1 to 9999
    oor3_d = ($signed(zf) < $signed(NW'(Z_MIN))) || ($signed(zf) > $signed(NW'(Z_MAX)));
    z3_d   = zf[Z_W-1:0];
    dd     = (DN_W+1)'(dn_a) - (DN_W+1)'(dn_b);
    mag3_d = dd[DN_W] ? DN_W'(-dd) : DN_W'(dd);
  end

  // ---------------------------------------------------------------------------
  // stages 4 to 11: civil date rebuild and year fraction of the difference
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0] cv_year;
  logic [MON_W-1:0]  cv_month;
  logic [DAY_W-1:0]  cv_day;
  logic [FRAC_W-1:0] frac9, frac10_q, frac11_q;

  cda_civil u_civil (
    .clk_i   (clk_i),
    .z_i     (z3_q),
    .year_o  (cv_year),
    .month_o (cv_month),
    .day_o   (cv_day)
  );

  cda_days_frac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_frac (
    .clk_i  (clk_i),
    .mag_i  (mag3_q),
    .neg_i  (dneg3_q),
    .frac_o (frac9)
  );

  // ---------------------------------------------------------------------------
  // control travels alongside the data
  // ---------------------------------------------------------------------------
  logic [LAST:3]   oor_q;
  logic [LAST:1]   vld_q;
  logic            done_q;

  always_ff @(posedge clk_i) begin
    prod1_q  <= prod1_d;
    neg1_q   <= yf[FRAC_W-1];
    sh2_q    <= sh2_d;
    neg2_q   <= neg1_q;
    z3_q     <= z3_d;
    mag3_q   <= mag3_d;
    dneg3_q  <= dd[DN_W];
    frac10_q <= frac9;
    frac11_q <= frac10_q;
    ctl_q[1] <= ctl_d;
    for (int i = 2; i <= LAST; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
    oor_q    <= {oor_q[LAST-1:3], oor3_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[LAST-1:1], start};
      done_q <= vld_q[LAST];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 12: output register, fields that the op does not use read zero
  // ---------------------------------------------------------------------------
  logic [YEAR_W-1:0] res_year_d, res_year_q;
  logic [MON_W-1:0]  res_month_d, res_month_q;
  logic [DAY_W-1:0]  res_day_d, res_day_q;
  logic [FRAC_W-1:0] year_diff_d, year_diff_q;
  logic              a_before_b_d, a_before_b_q;
  logic              dates_equal_d, dates_equal_q;
  logic              oor_d, oor_q12;

  always_comb begin
    res_year_d    = '0;
    res_month_d   = '0;
    res_day_d     = '0;
    year_diff_d   = '0;
    a_before_b_d  = 1'b0;
    dates_equal_d = 1'b0;
    oor_d         = 1'b0;
    unique case (ctl_q[LAST].op) inside
      OP_ADD, OP_SUB: begin
        if (oor_q[LAST]) begin
          oor_d = 1'b1;
        end else begin
          res_year_d  = cv_year;
          res_month_d = cv_month;
          res_day_d   = cv_day;
        end
      end
      OP_DIFF: begin
        year_diff_d   = frac11_q;
        a_before_b_d  = ctl_q[LAST].a_before_b;
        dates_equal_d = ctl_q[LAST].dates_equal;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_year_q    <= res_year_d;
    res_month_q   <= res_month_d;
    res_day_q     <= res_day_d;
    year_diff_q   <= year_diff_d;
    a_before_b_q  <= a_before_b_d;
    dates_equal_q <= dates_equal_d;
    oor_q12       <= oor_d;
  end

  assign done_o         = done_q;
  assign res_year_o     = res_year_q;
  assign res_month_o    = res_month_q;
  assign res_day_o      = res_day_q;
  assign year_diff_o    = year_diff_q;
  assign a_before_b_o   = a_before_b_q;
  assign dates_equal_o  = dates_equal_q;
  assign out_of_range_o = oor_q12;

endmodule

// ===== hdl/cda_day_num.sv =====
// two-stage conversion of year, month and day into a linear day number
module cda_day_num (
  input  logic                        clk_i,
  input  logic [cda_pkg::YEAR_W-1:0]  year_i,
  input  logic [cda_pkg::MON_W-1:0]   month_i,
  input  logic [cda_pkg::DAY_W-1:0]   day_i,
  output logic [cda_pkg::DN_W-1:0]    dnum_o
);
  import cda_pkg::*;

  localparam int YW   = YEAR_W + 1;
  localparam int S100 = YW + 7;
  localparam int KW   = S100 - 6;
  localparam logic [KW-1:0] K100 = KW'(((64'd1 << S100) + 64'd99) / 64'd100);

  logic [MON_W-1:0]   mon_c;
  logic               early;
  logic [3:0]         mp;
  logic [YW-1:0]      yy;
  logic [YW+KW-1:0]   c100_prod;

  logic [DN_W-1:0]    y365_d, y365_q;
  logic [YW-3:0]      yq4_d, yq4_q;
  logic [7:0]         c100_d, c100_q;
  logic [9:0]         doyp1_d, doyp1_q;
  logic [DN_W-1:0]    dnum_d, dnum_q;

  // stage 1: clamp month, shift to a march-based year, scale
  always_comb begin
    if (month_i == MON_W'(0)) begin
      mon_c = MON_W'(1);
    end else if (month_i > MON_W'(12)) begin
      mon_c = MON_W'(12);
    end else begin
      mon_c = month_i;
    end
    early     = (mon_c <= MON_W'(2));
    mp        = early ? 4'(mon_c + MON_W'(9)) : 4'(mon_c - MON_W'(3));
    yy        = YW'(year_i) + YW'(YR_OFS) - YW'(early);
    c100_prod = (YW+KW)'(yy) * (YW+KW)'(K100);
    y365_d    = DN_W'(yy) * DN_W'(DAYS_YEAR);
    yq4_d     = yy[YW-1:2];
    c100_d    = c100_prod[S100 +: 8];
    doyp1_d   = 10'(month_start(mp)) + 10'(day_i);
  end

  // stage 2: leap corrections and day of year
  always_comb begin
    dnum_d = y365_q + DN_W'(yq4_q) - DN_W'(c100_q) + DN_W'(c100_q[7:2])
           + DN_W'(doyp1_q) - DN_W'(1);
  end

  always_ff @(posedge clk_i) begin
    y365_q  <= y365_d;
    yq4_q   <= yq4_d;
    c100_q  <= c100_d;
    doyp1_q <= doyp1_d;
    dnum_q  <= dnum_d;
  end

  assign dnum_o = dnum_q;

endmodule

// ===== hdl/cda_civil.sv =====
// eight-stage conversion of a day number back into year, month and day
module cda_civil (
  input  logic                        clk_i,
  input  logic [cda_pkg::Z_W-1:0]     z_i,
  output logic [cda_pkg::YEAR_W-1:0]  year_o,
  output logic [cda_pkg::MON_W-1:0]   month_o,
  output logic [cda_pkg::DAY_W-1:0]   day_o
);
  import cda_pkg::*;

  localparam int SERA   = Z_W + 18;
  localparam int S1460  = 29;
  localparam int S36524 = 34;
  localparam int S100   = 16;
  localparam int S153   = 19;
  localparam logic [22:0] KERA   =
    23'(((64'd1 << SERA) + 64'd146096) / 64'd146097);
  localparam logic [18:0] K1460  = 19'(((64'd1 << S1460) + 64'd1459) / 64'd1460);
  localparam logic [18:0] K36524 = 19'(((64'd1 << S36524) + 64'd36523) / 64'd36524);
  localparam logic [9:0]  K100   = 10'(((64'd1 << S100) + 64'd99) / 64'd100);
  localparam logic [11:0] K153   = 12'(((64'd1 << S153) + 64'd152) / 64'd153);

  logic [Z_W+22:0] pera;
  logic [36:0]     p1460, p36524, p365;
  logic [18:0]     p100;
  logic [10:0]     x153;
  logic [22:0]     p153;

  logic [4:0]  era1_d, era1_q, era2_q, era3_q, era4_q, era5_q;
  logic [Z_W-1:0] z1_q;
  logic [17:0] doe2_d, doe2_q, doe3_q, doe4_q, doe5_q;
  logic [6:0]  n1460_d, n1460_q;
  logic [2:0]  n36524_d, n36524_q;
  logic        full_d, full_q;
  logic [17:0] t_d, t_q;
  logic [8:0]  yoe_d, yoe_q;
  logic [8:0]  doy6_d, doy6_q, doy7_q;
  logic [YEAR_W-1:0] yr6_d, yr6_q, yr7_q;
  logic [3:0]  mp_d, mp_q;
  logic [YEAR_W-1:0] year_d, year_q;
  logic [MON_W-1:0]  month_d, month_q;
  logic [DAY_W-1:0]  day_d, day_q;

  always_comb begin
    // 400-year era
    pera     = (Z_W+23)'(z_i) * (Z_W+23)'(KERA);
    era1_d   = pera[SERA +: 5];
    // day of era
    doe2_d   = 18'(z1_q - Z_W'(era1_q) * Z_W'(ERA_DAYS));
    // leap day counts inside the era
    p1460    = 37'(doe2_q) * 37'(K1460);
    p36524   = 37'(doe2_q) * 37'(K36524);
    n1460_d  = p1460[S1460 +: 7];
    n36524_d = p36524[S36524 +: 3];
    full_d   = (doe2_q == 18'(ERA_DAYS - 1));
    t_d      = doe3_q - 18'(n1460_q) + 18'(n36524_q) - 18'(full_q);
    // year of era
    p365     = 37'(t_q) * 37'(K365);
    yoe_d    = p365[S365 +: 9];
    // day of march-based year
    p100     = 19'(yoe_q) * 19'(K100);
    doy6_d   = 9'(doe5_q - 18'(yoe_q) * 18'(DAYS_YEAR) - 18'(yoe_q[8:2])
                  + 18'(p100[S100 +: 3]));
    yr6_d    = YEAR_W'(yoe_q) + YEAR_W'(era5_q) * YEAR_W'(YR_OFS);
    // march-based month
    x153     = 11'(doy6_q) * 11'(5) + 11'(2);
    p153     = 23'(x153) * 23'(K153);
    mp_d     = p153[S153 +: 4];
    // back to january-based month and calendar year
    day_d    = DAY_W'(doy7_q - month_start(mp_q) + 9'd1);
    month_d  = (mp_q < 4'd10) ? MON_W'(mp_q + 4'd3) : MON_W'(mp_q - 4'd9);
    year_d   = yr7_q + YEAR_W'(mp_q >= 4'd10);
  end

  always_ff @(posedge clk_i) begin
    era1_q   <= era1_d;
    z1_q     <= z_i;
    era2_q   <= era1_q;
    doe2_q   <= doe2_d;
    era3_q   <= era2_q;
    doe3_q   <= doe2_q;
    n1460_q  <= n1460_d;
    n36524_q <= n36524_d;
    full_q   <= full_d;
    era4_q   <= era3_q;
    doe4_q   <= doe3_q;
    t_q      <= t_d;
    era5_q   <= era4_q;
    doe5_q   <= doe4_q;
    yoe_q    <= yoe_d;
    doy6_q   <= doy6_d;
    yr6_q    <= yr6_d;
    doy7_q   <= doy6_q;
    yr7_q    <= yr6_q;
    mp_q     <= mp_d;
    year_q   <= year_d;
    month_q  <= month_d;
    day_q    <= day_d;
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

// ===== hdl/cda_days_frac.sv =====
// six-stage rounded division of a day count by 365 into a saturated fixed-point year
module cda_days_frac #(
  parameter int unsigned FRAC_BITS = cda_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [cda_pkg::DN_W-1:0]    mag_i,
  input  logic                        neg_i,
  output logic [cda_pkg::FRAC_W-1:0]  frac_o
);
  import cda_pkg::*;

  localparam int SQ = DN_W + 9;
  localparam logic [23:0] KQ = 24'(((64'd1 << SQ) + 64'd364) / 64'd365);
  // 2**FRAC_BITS = 365 * A_HI + B_LO
  localparam logic [15:0] A_HI = 16'((64'd1 << FRAC_BITS) / 64'd365);
  localparam logic [8:0]  B_LO = 9'((64'd1 << FRAC_BITS) % 64'd365);
  localparam int QW = FRAC_BITS + 17;
  localparam logic [47:0] LIM_POS = 48'h0000_3FFF_FFFF;
  localparam logic [47:0] LIM_NEG = 48'h0000_4000_0000;

  logic [DN_W+23:0] pq;
  logic [36:0]      prb;
  logic [47:0]      qx, lim, sat;

  logic [DN_W-1:0]  mag1_q;
  logic [14:0]      qi1_d, qi1_q, qi2_q, qi3_q, qi4_q;
  logic [8:0]       r2_d, r2_q;
  logic [24:0]      ar3_d, ar3_q, ar4_q;
  logic [17:0]      rb3_d, rb3_q;
  logic [8:0]       rbq4_d, rbq4_q;
  logic [QW-1:0]    q5_d, q5_q;
  logic [FRAC_W-1:0] frac6_d, frac6_q;
  logic             neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;

  always_comb begin
    // whole quotient and remainder by 365
    pq      = (DN_W+24)'(mag_i) * (DN_W+24)'(KQ);
    qi1_d   = pq[SQ +: 15];
    r2_d    = 9'(mag1_q - DN_W'(qi1_q) * DN_W'(DAYS_YEAR));
    // remainder scaled by 2**FRAC_BITS, split around 365
    ar3_d   = 25'(r2_q) * 25'(A_HI);
    rb3_d   = 18'(r2_q) * 18'(B_LO) + 18'(DAYS_HALF);
    prb     = 37'(rb3_q) * 37'(K365);
    rbq4_d  = prb[S365 +: 9];
    q5_d    = (QW'(qi4_q) << FRAC_BITS) + QW'(ar4_q) + QW'(rbq4_q);
    // saturate then apply sign
    qx      = 48'(q5_q);
    lim     = neg5_q ? LIM_NEG : LIM_POS;
    sat     = (qx > lim) ? lim : qx;
    frac6_d = neg5_q ? FRAC_W'(-sat) : FRAC_W'(sat);
  end

  always_ff @(posedge clk_i) begin
    mag1_q  <= mag_i;
    qi1_q   <= qi1_d;
    neg1_q  <= neg_i;
    r2_q    <= r2_d;
    qi2_q   <= qi1_q;
    neg2_q  <= neg1_q;
    ar3_q   <= ar3_d;
    rb3_q   <= rb3_d;
    qi3_q   <= qi2_q;
    neg3_q  <= neg2_q;
    rbq4_q  <= rbq4_d;
    ar4_q   <= ar3_q;
    qi4_q   <= qi3_q;
    neg4_q  <= neg3_q;
    q5_q    <= q5_d;
    neg5_q  <= neg4_q;
    frac6_q <= frac6_d;
  end

  assign frac_o = frac6_q;

endmodule

// ===== bench/tb_civil_date_arithmetic_unit.sv =====
// self-checking bench for the civil date unit: date shifts, date differences and flags
module tb_civil_date_arithmetic_unit;
  import cda_pkg::*;

  localparam int unsigned FRAC_BITS = FRAC_BITS_DEF;
  // op code with no operation behind it, every result field stays zero
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam longint YEAR_LO = 1;
  localparam longint YEAR_HI = 9999;
  // largest year fraction in range, 10000 years in q16
  localparam int FRAC_SPAN = 655360000;
  localparam int RAND_WORDS = 1900;
  localparam int unsigned CYCLE_LIMIT = 200000;
  // drain after the last expected done word, to catch any stray one
  localparam int DRAIN_CYCLES = 24;

  // one start word as driven on the input ports
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [YEAR_W-1:0] a_year;
    logic [MON_W-1:0]  a_month;
    logic [DAY_W-1:0]  a_day;
    logic [YEAR_W-1:0] b_year;
    logic [MON_W-1:0]  b_month;
    logic [DAY_W-1:0]  b_day;
    logic [FRAC_W-1:0] yr_frac;
  } date_word_t;

  // one done word as seen on the output ports
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [FRAC_W-1:0] diff;
    logic              lt;
    logic              equal;
    logic              oor;
  } date_result_t;

  // holds the predicted done words in order and checks each arriving one
  class date_scoreboard;
    date_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
    endfunction

    // day count from 1970-01-01, month clamped to 1..12, day zero is the day before the 1st
    function longint day_count(logic [YEAR_W-1:0] yr, logic [MON_W-1:0] mo,
                               logic [DAY_W-1:0] dy);
      longint y, m, d, era, yoe, doy, doe;
      y = longint'(yr);
      m = longint'(mo);
      d = longint'(dy);
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      // march-based year, jan and feb belong to the year before
      if (m <= 2) y = y - 1;
      era = (y >= 0 ? y : y - 399) / 400;
      yoe = y - era * 400;
      doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468;
    endfunction

    // inverse of day_count
    function void civil_from_count(longint z, output longint yo, output longint mo,
                                   output longint dd);
      longint era, doe, yoe, doy, mp;
      z = z + 719468;
      era = (z >= 0 ? z : z - 146096) / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yo = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      dd = doy - (153 * mp + 2) / 5 + 1;
      mo = mp < 10 ? mp + 3 : mp - 9;
      if (mo <= 2) yo = yo + 1;
    endfunction

    // year fraction times 365, rounded half away from zero
    function longint frac_days(logic [FRAC_W-1:0] raw);
      logic neg;
      longint unsigned mag, q;
      neg = raw[FRAC_W-1];
      mag = neg ? (64'h8000_0000 - 64'(raw)) : 64'(raw);
      q = (mag * 64'(DAYS_YEAR) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // day difference over 365 in fixed point, nearest, saturated to 31 bits signed
    function logic [FRAC_W-1:0] days_frac(longint delta);
      logic neg;
      longint unsigned mag, q;
      longint s;
      neg = delta < 0;
      mag = neg ? longint'(-delta) : longint'(delta);
      q = ((mag << FRAC_BITS) + 64'(DAYS_HALF)) / 64'(DAYS_YEAR);
      if (q > 64'h4000_0000) q = 64'h4000_0000;
      s = neg ? -longint'(q) : longint'(q);
      if (s > 64'sh3FFF_FFFF) s = 64'sh3FFF_FFFF;
      if (s < -64'sh4000_0000) s = -64'sh4000_0000;
      return FRAC_W'(s);
    endfunction

    function date_result_t date_outcome(date_word_t w);
      date_result_t r;
      longint n, y, m, d;
      r = '0;
      if (w.op == OP_ADD || w.op == OP_SUB) begin
        n = day_count(w.a_year, w.a_month, w.a_day);
        n = (w.op == OP_ADD) ? n + frac_days(w.yr_frac) : n - frac_days(w.yr_frac);
        civil_from_count(n, y, m, d);
        if (y < YEAR_LO || y > YEAR_HI) begin
          r.oor = 1'b1;
        end else begin
          r.year  = YEAR_W'(y);
          r.month = MON_W'(m);
          r.day   = DAY_W'(d);
        end
      end else if (w.op == OP_DIFF) begin
        r.diff = days_frac(day_count(w.a_year, w.a_month, w.a_day) -
                           day_count(w.b_year, w.b_month, w.b_day));
        // flags look at the raw fields, not the clamped month
        if (w.a_year != w.b_year) r.lt = w.a_year < w.b_year;
        else if (w.a_month != w.b_month) r.lt = w.a_month < w.b_month;
        else r.lt = w.a_day < w.b_day;
        r.equal = (w.a_year == w.b_year) && (w.a_month == w.b_month) &&
                  (w.a_day == w.b_day);
      end
      return r;
    endfunction

    function void note_word(date_word_t w);
      expected_q.push_back(date_outcome(w));
    endfunction

    function void check_result(date_result_t got);
      date_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected done word: y=%0d m=%0d d=%0d diff=%h lt=%b eq=%b oor=%b",
                   got.year, got.month, got.day, got.diff, got.lt, got.equal, got.oor);
        return;
      end
      want = expected_q.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.diff !== want.diff || got.lt !== want.lt ||
          got.equal !== want.equal || got.oor !== want.oor) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: y=%0d m=%0d d=%0d diff=%h lt=%b eq=%b oor=%b",
                   want.year, want.month, want.day, want.diff, want.lt, want.equal,
                   want.oor);
          $display("         got: y=%0d m=%0d d=%0d diff=%h lt=%b eq=%b oor=%b",
                   got.year, got.month, got.day, got.diff, got.lt, got.equal, got.oor);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                     start       = 1'b0;
  logic [OP_W-1:0]          op_i        = '0;
  logic [YEAR_W-1:0]        a_year_i    = '0;
  logic [MON_W-1:0]         a_month_i   = '0;
  logic [DAY_W-1:0]         a_day_i     = '0;
  logic [YEAR_W-1:0]        b_year_i    = '0;
  logic [MON_W-1:0]         b_month_i   = '0;
  logic [DAY_W-1:0]         b_day_i     = '0;
  logic signed [FRAC_W-1:0] year_frac_i = '0;

  // block outputs
  logic                     busy;
  logic                     done_o;
  logic [YEAR_W-1:0]        res_year_o;
  logic [MON_W-1:0]         res_month_o;
  logic [DAY_W-1:0]         res_day_o;
  logic signed [FRAC_W-1:0] year_diff_o;
  logic                     a_before_b_o;
  logic                     dates_equal_o;
  logic                     out_of_range_o;

  date_scoreboard sb = new();
  date_result_t   seen_res;
  int unsigned    cycles = 0;

  civil_date_arithmetic_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .a_year_i      (a_year_i),
    .a_month_i     (a_month_i),
    .a_day_i       (a_day_i),
    .b_year_i      (b_year_i),
    .b_month_i     (b_month_i),
    .b_day_i       (b_day_i),
    .year_frac_i   (year_frac_i),
    .done_o        (done_o),
    .res_year_o    (res_year_o),
    .res_month_o   (res_month_o),
    .res_day_o     (res_day_o),
    .year_diff_o   (year_diff_o),
    .a_before_b_o  (a_before_b_o),
    .dates_equal_o (dates_equal_o),
    .out_of_range_o(out_of_range_o)
  );

  // period of 4, high then low
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // done words cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      seen_res.year   = res_year_o;
      seen_res.month  = res_month_o;
      seen_res.day    = res_day_o;
      seen_res.diff   = year_diff_o;
      seen_res.lt     = a_before_b_o;
      seen_res.equal  = dates_equal_o;
      seen_res.oor    = out_of_range_o;
      sb.check_result(seen_res);
    end
  end

  // watchdog against a hung handshake or a lost done word
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic date_word_t pack_word(logic [OP_W-1:0] op, int ay, int am, int ad,
                                           int by, int bm, int bd, int frac);
    date_word_t w;
    w.op        = op;
    w.a_year    = YEAR_W'(ay);
    w.a_month   = MON_W'(am);
    w.a_day     = DAY_W'(ad);
    w.b_year    = YEAR_W'(by);
    w.b_month   = MON_W'(bm);
    w.b_day     = DAY_W'(bd);
    w.yr_frac   = FRAC_W'(frac);
    return w;
  endfunction

  // mostly valid dates with random content, a slice of full-width noise
  function automatic date_word_t random_word();
    date_word_t w;
    int unsigned kind, mag;
    kind = $urandom_range(99);
    if (kind < 85) begin
      w.op      = OP_W'($urandom_range(2));
      w.a_month = MON_W'($urandom_range(12, 1));
      w.a_day   = DAY_W'($urandom_range(31, 1));
      // some dates near either end of the year range so the shift can leave it
      case ($urandom_range(9))
        0:       w.a_year = YEAR_W'($urandom_range(30, 1));
        1:       w.a_year = YEAR_W'($urandom_range(9999, 9970));
        default: w.a_year = YEAR_W'($urandom_range(9999, 1));
      endcase
      if ($urandom_range(9) < 3) begin
        // second date equal to the first or one field off, to hit the flags
        w.b_year  = w.a_year;
        w.b_month = w.a_month;
        w.b_day   = w.a_day;
        case ($urandom_range(3))
          0: w.b_year  = YEAR_W'($urandom_range(9999, 1));
          1: w.b_month = MON_W'($urandom_range(12, 1));
          2: w.b_day   = DAY_W'($urandom_range(31, 1));
          default: ;
        endcase
      end else begin
        w.b_year  = YEAR_W'($urandom_range(9999, 1));
        w.b_month = MON_W'($urandom_range(12, 1));
        w.b_day   = DAY_W'($urandom_range(31, 1));
      end
      // short shifts half the time, else any shift within ten thousand years
      mag = ($urandom_range(9) < 5) ? $urandom_range(1 << 18) : $urandom_range(FRAC_SPAN);
      w.yr_frac = $urandom_range(1) ? FRAC_W'(-int'(mag)) : FRAC_W'(mag);
    end else begin
      w.op        = OP_W'($urandom);
      w.a_year    = YEAR_W'($urandom);
      w.a_month   = MON_W'($urandom);
      w.a_day     = DAY_W'($urandom);
      w.b_year    = YEAR_W'($urandom);
      w.b_month   = MON_W'($urandom);
      w.b_day     = DAY_W'($urandom);
      w.yr_frac   = FRAC_W'($urandom);
    end
    return w;
  endfunction

  // entered at a falling edge, leaves at a falling edge; start stays high between words unless the sender idles
  task automatic send_word(input date_word_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start       = 1'b1;
    op_i        = w.op;
    a_year_i    = w.a_year;
    a_month_i   = w.a_month;
    a_day_i     = w.a_day;
    b_year_i    = w.b_year;
    b_month_i   = w.b_month;
    b_day_i     = w.b_day;
    year_frac_i = w.yr_frac;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
    @(negedge clk_i);
  endtask

  initial begin
    date_word_t  directed_q[$];
    int unsigned idle_pct;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // plain shifts, one year forward and one day back over a leap day
    directed_q.push_back(pack_word(OP_ADD, 2024, 1, 31, 0, 0, 0, 65536));
    directed_q.push_back(pack_word(OP_SUB, 2000, 3, 1, 0, 0, 0, 180));
    // month rollover: feb 29 in a century year, feb 31, day zero
    directed_q.push_back(pack_word(OP_ADD, 1900, 2, 29, 0, 0, 0, 0));
    directed_q.push_back(pack_word(OP_ADD, 2023, 2, 31, 0, 0, 0, 0));
    directed_q.push_back(pack_word(OP_ADD, 2023, 5, 0, 0, 0, 0, 0));
    // months outside 1..12 are clamped for the day count
    directed_q.push_back(pack_word(OP_ADD, 2023, 0, 10, 0, 0, 0, 0));
    directed_q.push_back(pack_word(OP_SUB, 2023, 15, 10, 0, 0, 0, 0));
    // one day past either end of the year range
    directed_q.push_back(pack_word(OP_SUB, 1, 1, 1, 0, 0, 0, 180));
    directed_q.push_back(pack_word(OP_ADD, 9999, 12, 31, 0, 0, 0, 180));
    // largest fractions both ways
    directed_q.push_back(pack_word(OP_ADD, 1, 1, 1, 0, 0, 0, FRAC_SPAN));
    directed_q.push_back(pack_word(OP_SUB, 9999, 12, 31, 0, 0, 0, FRAC_SPAN));
    directed_q.push_back(pack_word(OP_ADD, 5000, 6, 15, 0, 0, 0, -FRAC_SPAN));
    directed_q.push_back(pack_word(OP_ADD, 16383, 15, 31, 0, 0, 0, -1073741824));
    // half a year is an exact half day tie, rounded away from zero
    directed_q.push_back(pack_word(OP_ADD, 2001, 1, 1, 0, 0, 0, 32768));
    directed_q.push_back(pack_word(OP_ADD, 2001, 1, 1, 0, 0, 0, -32768));
    // a date in year zero lies outside the year range
    directed_q.push_back(pack_word(OP_ADD, 0, 2, 29, 0, 0, 0, 0));
    // compare: equal, before by day, after by month, before by year against a larger month
    directed_q.push_back(pack_word(OP_DIFF, 2020, 7, 4, 2020, 7, 4, 0));
    directed_q.push_back(pack_word(OP_DIFF, 2020, 7, 4, 2020, 7, 5, 0));
    directed_q.push_back(pack_word(OP_DIFF, 2020, 8, 1, 2020, 7, 31, 0));
    directed_q.push_back(pack_word(OP_DIFF, 2019, 12, 31, 2020, 1, 1, 0));
    // difference saturates both ways
    directed_q.push_back(pack_word(OP_DIFF, 16383, 15, 31, 0, 0, 0, 0));
    directed_q.push_back(pack_word(OP_DIFF, 0, 0, 0, 16383, 15, 31, 0));
    // same day count, raw month differs: not equal, a before b
    directed_q.push_back(pack_word(OP_DIFF, 2020, 0, 5, 2020, 1, 5, 0));
    // spare op code gives all zero
    directed_q.push_back(pack_word(OP_SPARE, 16383, 15, 31, 16383, 15, 31, -1));

    foreach (directed_q[i]) send_word(directed_q[i], 24);

    // three idling phases for the sender: light, heavy, none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 67 : 0;
      for (int i = 0; i < RAND_WORDS / 3; i++) send_word(random_word(), idle_pct);
    end

    start = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cda_pkg.sv
hdl/cda_day_num.sv
hdl/cda_civil.sv
hdl/cda_days_frac.sv
hdl/civil_date_arithmetic_unit.sv
bench/tb_civil_date_arithmetic_unit.sv
